### rtl/assert_macros.svh
// Assertion macros for the checker file of the page table manager.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define TLPT_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds during reset.
`define TLPT_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tlpt_pkg.sv
// Types, codes and sizes for the two-level page table manager.
// Depends on nothing; used by every module of the block but tlpt_ram.
package tlpt_pkg;

  localparam int FREE_DEPTH  = 4096;
  localparam int FREE_AW     = $clog2(FREE_DEPTH);
  localparam int FREE_CW     = $clog2(FREE_DEPTH + 1);

  localparam int DIR_ENTRIES = 1024;
  localparam int DIR_AW      = 10;
  localparam int PTE_ENTRIES = 1048576;
  localparam int PTE_AW      = 20;

  localparam logic [31:0] FRAME_MASK = 32'hFFFF_F000;
  localparam logic [31:0] DIR_FLAGS  = 32'h0000_0007;

  typedef enum logic [2:0] {
    ACT_ACQUIRE   = 3'd0,
    ACT_RELEASE   = 3'd1,
    ACT_MAP       = 3'd2,
    ACT_UNMAP     = 3'd3,
    ACT_TRANSLATE = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_NO_PAGES   = 2'd1,
    STS_NOT_MAPPED = 2'd2,
    STS_FULL       = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic        push;
    logic        pop;
    logic [31:0] data;
  } stack_cmd_t;

  typedef struct packed {
    logic        empty;
    logic        full;
    logic [31:0] top;
  } stack_stat_t;

endpackage

### rtl/tlpt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module tlpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tlpt_stack.sv
// Free page stack: fill count plus a RAM holding the page addresses.
// Depends on tlpt_pkg and tlpt_ram.
module tlpt_stack (
  input  logic                 clk,
  input  logic                 rst,
  input  tlpt_pkg::stack_cmd_t cmd,
  output tlpt_pkg::stack_stat_t stat
);
  import tlpt_pkg::*;

  logic [FREE_CW-1:0] count;
  logic [FREE_CW-1:0] count_m1;

  assign count_m1 = count - FREE_CW'(1);

  // Top of stack is read continuously through the registered read port; valid in the cycle after count settles.
  tlpt_ram #(
    .WIDTH(32),
    .DEPTH(FREE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(count[FREE_AW-1:0]),
    .wdata(cmd.data),
    .raddr(count_m1[FREE_AW-1:0]),
    .rdata(stat.top)
  );

  assign stat.empty = (count == '0);
  assign stat.full  = (count == FREE_CW'(FREE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push) begin
      count <= count + FREE_CW'(1);
    end else if (cmd.pop) begin
      count <= count_m1;
    end
  end

endmodule

### rtl/two_level_page_table_manager_core.sv
// Two-level page table manager with a free page stack: top level.
// Depends on tlpt_pkg, tlpt_ram and tlpt_stack.
//
// Usage:
//   Request channel (s_*): s_tuser carries the action code (acquire, release,
//   map, unmap, translate); s_tdata carries virt_addr, phys_addr, page_flags.
//   Response channel (m_*): m_tdata carries result_addr; m_tuser carries
//   status and dir_allocated. Every request yields exactly one response.
//   Timing: a request is accepted in the idle cycle, the directory, page
//   table and stack-top RAMs are read at that edge, and the execute state
//   then decides, writes back and loads the response register as soon as
//   that register is free; the reads of the table RAMs are registered.
//   Reset: the stack empties at once; then a clearing pass writes zero to
//   every page table entry (and the directory alongside), one entry a cycle,
//   with s_tready held low meanwhile.
//   Stall: the response register holds while m_tready is low; the block stays
//   in its execute state and takes no new request until the register frees up.
module two_level_page_table_manager_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // [31:0] virt_addr, [63:32] phys_addr,
                                // [75:64] page_flags, [79:76] zero
  input  logic [2:0]  s_tuser,  // [2:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // [31:0] result_addr
  output logic [2:0]  m_tuser   // [1:0] status, [2] dir_allocated
);
  import tlpt_pkg::*;

  state_t state, state_next;

  logic [PTE_AW-1:0] clr_cnt;
  logic              clearing;
  logic              exec_go;
  logic              out_free;

  // Latched request
  logic [2:0]  req_action;
  logic [31:0] req_virt;
  logic [31:0] req_phys;
  logic [11:0] req_flags;

  // Table RAM ports
  logic              dir_we;
  logic [DIR_AW-1:0] dir_waddr;
  logic [31:0]       dir_wdata;
  logic [DIR_AW-1:0] dir_raddr;
  logic [31:0]       dir_rdata;
  logic              pte_we;
  logic [PTE_AW-1:0] pte_waddr;
  logic [31:0]       pte_wdata;
  logic [PTE_AW-1:0] pte_raddr;
  logic [31:0]       pte_rdata;

  stack_cmd_t  stk_cmd;
  stack_stat_t stk_stat;

  // Decision of the executing request
  logic        x_dir_we;
  logic        x_pte_we;
  logic [31:0] x_pte_wdata;
  logic [31:0] x_result;
  status_t     x_status;
  logic        x_alloc;
  action_t     act;

  assign out_free = !m_tvalid || m_tready;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:  if (s_tvalid) state_next = ST_EXEC;
      ST_EXEC:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    clearing = 1'b0;
    exec_go  = 1'b0;
    case (state)
      ST_CLEAR: clearing = 1'b1;
      ST_IDLE:  s_tready = 1'b1;
      ST_EXEC:  exec_go  = out_free;
      default:  clearing = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (clearing) begin
        clr_cnt <= clr_cnt + PTE_AW'(1);
      end
    end
  end

  // Capture the request on acceptance.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_action <= s_tuser;
      req_virt   <= s_tdata[31:0];
      req_phys   <= s_tdata[63:32];
      req_flags  <= s_tdata[75:64];
    end
  end

  // ---------------------------------------------------------------- memories
  // Read from the incoming request while idle, from the latched one while
  // executing, so read data stays valid through a response stall.
  assign dir_raddr = s_tready ? s_tdata[31:22] : req_virt[31:22];
  assign pte_raddr = s_tready ? s_tdata[31:12] : req_virt[31:12];

  assign dir_we    = clearing ? (clr_cnt[PTE_AW-1:DIR_AW] == '0) : (exec_go && x_dir_we);
  assign dir_waddr = clearing ? clr_cnt[DIR_AW-1:0] : req_virt[31:22];
  assign dir_wdata = clearing ? 32'd0 : (stk_stat.top | DIR_FLAGS);

  assign pte_we    = clearing || (exec_go && x_pte_we);
  assign pte_waddr = clearing ? clr_cnt : req_virt[31:12];
  assign pte_wdata = clearing ? 32'd0 : x_pte_wdata;

  tlpt_ram #(
    .WIDTH(32),
    .DEPTH(DIR_ENTRIES)
  ) u_dir_ram (
    .clk  (clk),
    .we   (dir_we),
    .waddr(dir_waddr),
    .wdata(dir_wdata),
    .raddr(dir_raddr),
    .rdata(dir_rdata)
  );

  tlpt_ram #(
    .WIDTH(32),
    .DEPTH(PTE_ENTRIES)
  ) u_pte_ram (
    .clk  (clk),
    .we   (pte_we),
    .waddr(pte_waddr),
    .wdata(pte_wdata),
    .raddr(pte_raddr),
    .rdata(pte_rdata)
  );

  tlpt_stack u_stack (
    .clk (clk),
    .rst (rst),
    .cmd (stk_cmd),
    .stat(stk_stat)
  );

  // ---------------------------------------------------------------- execute
  assign act = action_t'(req_action);

  always_comb begin
    x_dir_we    = 1'b0;
    x_pte_we    = 1'b0;
    x_pte_wdata = req_phys | {20'd0, req_flags};
    x_result    = 32'd0;
    x_status    = STS_OK;
    x_alloc     = 1'b0;
    stk_cmd     = '0;
    stk_cmd.data = req_phys;
    case (act)
      ACT_ACQUIRE: begin
        if (stk_stat.empty) begin
          x_status = STS_NO_PAGES;
        end else begin
          x_result    = stk_stat.top;
          stk_cmd.pop = exec_go;
        end
      end
      ACT_RELEASE: begin
        if (stk_stat.full) begin
          x_status = STS_FULL;  // drop the page
        end else begin
          stk_cmd.push = exec_go;
        end
      end
      ACT_MAP: begin
        if (dir_rdata[0]) begin
          x_pte_we = 1'b1;
        end else if (stk_stat.empty) begin
          x_status = STS_NO_PAGES;  // no frame for the directory entry
        end else begin
          // Allocate a directory frame from the stack, then write the entry.
          stk_cmd.pop = exec_go;
          x_dir_we    = 1'b1;
          x_pte_we    = 1'b1;
          x_alloc     = 1'b1;
        end
      end
      ACT_UNMAP: begin
        if (!pte_rdata[0]) begin
          x_status = STS_NOT_MAPPED;
        end else begin
          x_result    = pte_rdata & FRAME_MASK;
          x_pte_we    = 1'b1;
          x_pte_wdata = 32'd0;
        end
      end
      ACT_TRANSLATE: begin
        if (!pte_rdata[0]) begin
          x_status = STS_NOT_MAPPED;
        end else begin
          x_result = pte_rdata & FRAME_MASK;
        end
      end
      default: x_status = STS_OK;  // unknown action: no effect
    endcase
  end

  // ---------------------------------------------------------------- response
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      m_tdata <= x_result;
      m_tuser <= {x_alloc, x_status};
    end
  end

endmodule

### rtl/tlpt_checker.sv
// Port-level assertions for the page table manager, bound to the top level.
// Depends on assert_macros.svh, tlpt_pkg and two_level_page_table_manager_core.
`include "assert_macros.svh"

module tlpt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [79:0] s_tdata,
  input logic [2:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [2:0]  m_tuser
);
  import tlpt_pkg::*;

  // Clearing pass keeps requests out right after reset.
  `TLPT_ASSERT_ALWAYS(a_clear_after_rst, clk, rst |=> !s_tready, "request taken during clear")

  // One request at a time: an accepted request blocks the next cycle.
  `TLPT_ASSERT(a_one_at_a_time, clk, rst, (s_tvalid && s_tready) |=> !s_tready, "overlapping requests")

  // A directory allocation only comes with a successful map.
  `TLPT_ASSERT(a_alloc_ok, clk, rst, (m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == STS_OK), "alloc with error status")

  // Stalled response holds.
  `TLPT_ASSERT(a_resp_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "response dropped or changed under stall")

endmodule

bind two_level_page_table_manager_core tlpt_checker u_tlpt_checker (.*);

### tb/testbench.sv
// Self-checking bench for two_level_page_table_manager_core: directed and random requests
// on the request stream, each response checked against an in-bench page table predictor.
// Depends on tlpt_pkg for the action and status codes and the stack depth.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpt_pkg::*;

  localparam logic [2:0] ACT_LAST_CODE = 3'd7;  // highest code on the 3-bit action field
  localparam int         PRESENT_BIT   = 0;
  localparam int         POOL_DIRS     = 6;
  localparam int         RANDOM_COUNT  = 2000;

  typedef struct {
    logic [2:0]  act;
    logic [31:0] virt;
    logic [31:0] phys;
    logic [11:0] flags;
  } request_t;

  typedef struct {
    logic [31:0] result_addr;
    status_t     status;
    logic        dir_alloc;
  } response_t;

  typedef enum { RX_STREAM, RX_COIN, RX_SPARSE } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;  // [31:0] virt_addr, [63:32] phys_addr, [75:64] page_flags
  logic [2:0]  s_tuser = '0;  // [2:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // [31:0] result_addr
  logic [2:0]  m_tuser;       // [1:0] status, [2] dir_allocated

  two_level_page_table_manager_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Predictor state: free page stack, directory and a sparse page table.
  logic [31:0] free_stack [FREE_DEPTH];
  int          free_top = 0;
  logic [31:0] dir_table [DIR_ENTRIES];
  logic [31:0] pte_table [bit [19:0]];

  request_t    pending_requests [$];
  response_t   awaited_responses [$];
  int          total_requests = 0;
  int          requests_taken = 0;
  int          responses_seen = 0;
  int          mismatches = 0;
  bit          req_taken = 1'b0;
  logic [9:0]  pool_dirs [POOL_DIRS];

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL two_level_page_table_manager_core");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one request to the predicted state and return the response it should yield.
  function automatic response_t page_table_response(input logic [2:0] act,
                                                    input logic [31:0] va,
                                                    input logic [31:0] pa,
                                                    input logic [11:0] flags);
    response_t  r;
    logic [9:0] dir_idx;
    logic [19:0] pte_idx;
    logic [31:0] entry;
    r.result_addr = '0;
    r.status      = STS_OK;
    r.dir_alloc   = 1'b0;
    dir_idx = va[31:22];
    pte_idx = va[31:12];
    entry   = pte_table.exists(pte_idx) ? pte_table[pte_idx] : '0;
    case (act)
      ACT_ACQUIRE: begin
        if (free_top == 0) begin
          r.status = STS_NO_PAGES;
        end else begin
          free_top--;
          r.result_addr = free_stack[free_top];
        end
      end
      ACT_RELEASE: begin
        if (free_top >= FREE_DEPTH) begin
          r.status = STS_FULL;
        end else begin
          free_stack[free_top] = pa;
          free_top++;
        end
      end
      ACT_MAP: begin
        // An absent directory entry needs a frame; with an empty stack nothing is written.
        if (!dir_table[dir_idx][PRESENT_BIT] && free_top == 0) begin
          r.status = STS_NO_PAGES;
        end else begin
          if (!dir_table[dir_idx][PRESENT_BIT]) begin
            free_top--;
            dir_table[dir_idx] = free_stack[free_top] | DIR_FLAGS;
            r.dir_alloc = 1'b1;
          end
          pte_table[pte_idx] = pa | {20'b0, flags};
        end
      end
      ACT_UNMAP: begin
        if (!entry[PRESENT_BIT]) begin
          r.status = STS_NOT_MAPPED;
        end else begin
          r.result_addr = entry & FRAME_MASK;
          pte_table.delete(pte_idx);
        end
      end
      ACT_TRANSLATE: begin
        if (!entry[PRESENT_BIT]) r.status = STS_NOT_MAPPED;
        else r.result_addr = entry & FRAME_MASK;
      end
      default: ;  // unknown codes leave everything as it is
    endcase
    return r;
  endfunction

  task automatic add_request(input logic [2:0] act, input logic [31:0] va,
                             input logic [31:0] pa, input logic [11:0] flags);
    request_t q;
    q.act   = act;
    q.virt  = va;
    q.phys  = pa;
    q.flags = flags;
    pending_requests.push_back(q);
  endtask

  // Mostly addresses inside a few directories so that map, translate and unmap meet.
  function automatic logic [31:0] pick_vaddr();
    logic [9:0]  d;
    logic [9:0]  pg;
    logic [11:0] low;
    if ($urandom_range(0, 99) < 15) return $urandom();
    d   = pool_dirs[$urandom_range(0, POOL_DIRS - 1)];
    pg  = 10'($urandom_range(0, 15));
    low = 12'($urandom_range(0, 4095));
    return {d, pg, low};
  endfunction

  // Sender: bursts of requests with random gaps; hold a request until it is taken.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    logic     valid_next;
    request_t q;
    valid_next = s_tvalid;
    if (rst) begin
      valid_next = 1'b0;
    end else if (!s_tvalid || req_taken) begin
      valid_next = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_requests.size() > 0) begin
        q = pending_requests.pop_front();
        s_tdata    <= {4'b0, q.flags, q.phys, q.virt};
        s_tuser    <= q.act;
        valid_next = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 23);
          gap_left   = $urandom_range(1, 6);
        end
      end
    end
    s_tvalid <= valid_next;
  end

  // Receiver: segments of steady, coin-flip or sparse stalls, plus one long hold-off
  // that backs the block up until it stops taking requests.
  int unsigned seg_left = 0;
  rx_mode_t    seg_mode = RX_STREAM;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk) begin
    logic ready_next;
    ready_next = 1'b1;
    if (!hold_done && responses_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      ready_next = 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(8, 64);
        seg_mode = rx_mode_t'($urandom_range(0, 2));
      end
      seg_left--;
      case (seg_mode)
        RX_STREAM: ready_next = 1'b1;
        RX_COIN:   ready_next = 1'($urandom_range(0, 1));
        default:   ready_next = ($urandom_range(0, 7) != 0);
      endcase
    end
    m_tready <= ready_next;
  end

  // Monitor: predict on each taken request, check each delivered response.
  always @(posedge clk) begin
    response_t want;
    req_taken = 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        req_taken = 1'b1;
        requests_taken++;
        awaited_responses.push_back(page_table_response(s_tuser, s_tdata[31:0],
                                                         s_tdata[63:32], s_tdata[75:64]));
      end
      if (m_tvalid && m_tready) begin
        responses_seen++;
        if (awaited_responses.size() == 0) begin
          report_mismatch("response with none awaited", m_tdata, '0);
        end else begin
          want = awaited_responses.pop_front();
          if (m_tdata !== want.result_addr)
            report_mismatch("result_addr", m_tdata, want.result_addr);
          if (m_tuser[1:0] !== want.status)
            report_mismatch("status", {30'b0, m_tuser[1:0]}, {30'b0, want.status});
          if (m_tuser[2] !== want.dir_alloc)
            report_mismatch("dir_allocated", {31'b0, m_tuser[2]}, {31'b0, want.dir_alloc});
        end
      end
    end
  end

  initial begin
    logic [2:0]  act;
    logic [31:0] va;
    logic [31:0] pa;
    logic [11:0] fl;
    int unsigned r;

    foreach (dir_table[i]) dir_table[i] = '0;
    pool_dirs[0] = '0;
    pool_dirs[1] = '1;
    for (int i = 2; i < POOL_DIRS; i++) pool_dirs[i] = 10'($urandom_range(0, DIR_ENTRIES - 1));

    // Directed: empty stack, unmapped reads, unknown codes, field extremes.
    add_request(ACT_ACQUIRE, 32'h0, 32'h0, 12'h0);
    add_request(ACT_MAP, 32'h0000_1000, 32'h0000_2001, 12'h001);  // needs a frame, none free
    add_request(ACT_TRANSLATE, 32'h0000_1000, 32'h0, 12'h0);
    add_request(ACT_UNMAP, 32'h0000_1000, 32'h0, 12'h0);
    for (int c = int'(ACT_TRANSLATE) + 1; c <= int'(ACT_LAST_CODE); c++)
      add_request(3'(c), 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    add_request(ACT_RELEASE, 32'h0, 32'h0000_0000, 12'h0);
    add_request(ACT_RELEASE, 32'h0, 32'hFFFF_FFFF, 12'h0);
    add_request(ACT_RELEASE, 32'h0, 32'h1234_5000, 12'h0);
    add_request(ACT_MAP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
    add_request(ACT_TRANSLATE, 32'hFFFF_F000, 32'h0, 12'h0);
    add_request(ACT_MAP, 32'h0000_0000, 32'h0000_0000, 12'h000);  // entry written not present
    add_request(ACT_TRANSLATE, 32'h0000_0000, 32'h0, 12'h0);
    add_request(ACT_MAP, 32'hFFC0_0000, 32'hABCD_E001, 12'h000);   // low paddr bit sets present
    add_request(ACT_TRANSLATE, 32'hFFC0_0ABC, 32'h0, 12'h0);
    add_request(ACT_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h0);
    add_request(ACT_UNMAP, 32'hFFFF_FFFF, 32'h0, 12'h0);
    add_request(ACT_TRANSLATE, 32'h0040_0000, 32'h0, 12'h0);       // directory never allocated
    add_request(ACT_ACQUIRE, 32'h0, 32'h0, 12'h0);
    add_request(ACT_ACQUIRE, 32'h0, 32'h0, 12'h0);

    // Random mix over a small address pool, with some noise.
    repeat (RANDOM_COUNT) begin
      r  = $urandom_range(0, 99);
      va = pick_vaddr();
      pa = $urandom();
      fl = 12'($urandom_range(0, 4095));
      if (r < 15) begin
        act = ACT_ACQUIRE;
      end else if (r < 35) begin
        act = ACT_RELEASE;
      end else if (r < 60) begin
        act = ACT_MAP;
        if ($urandom_range(0, 4) != 0) fl[PRESENT_BIT] = 1'b1;
      end else if (r < 72) begin
        act = ACT_UNMAP;
      end else if (r < 95) begin
        act = ACT_TRANSLATE;
      end else begin
        act = 3'($urandom_range(int'(ACT_TRANSLATE) + 1, int'(ACT_LAST_CODE)));
      end
      add_request(act, va, pa, fl);
    end

    total_requests = pending_requests.size();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (requests_taken < total_requests || awaited_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS two_level_page_table_manager_core");
    end else begin
      $display("FAIL two_level_page_table_manager_core");
    end
    $finish;
  end

endmodule
